// ----- design/tbm_pkg.sv -----
// tbm_pkg: shared types and constants for the typed byte memory
// holds command codes, result source codes and the controller/datapath structs
// no dependencies
package tbm_pkg;

    localparam int SIZE_W = 7;
    localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;

    typedef enum logic [2:0] {
        CMD_STORE_BYTE = 3'd0,
        CMD_STORE_HALF = 3'd1,
        CMD_STORE_WORD = 3'd2,
        CMD_STORE_STR  = 3'd3,
        CMD_LOAD_BYTE  = 3'd4,
        CMD_LOAD_HALF  = 3'd5,
        CMD_LOAD_WORD  = 3'd6,
        CMD_LOAD_STR   = 3'd7
    } cmd_t;

    typedef enum logic [1:0] {
        SRC_NOVAL = 2'd0,
        SRC_VIOL  = 2'd1,
        SRC_ACC   = 2'd2,
        SRC_CHAR  = 2'd3
    } out_src_t;

    typedef struct packed {
        logic     accept;
        logic     wr;
        logic     rd;
        logic     step;
        logic     out_load;
        out_src_t out_src;
        logic     out_last;
        logic     pend_load;
    } tbm_ctrl_t;

    typedef struct packed {
        logic viol;
        logic is_store;
        logic is_load_fixed;
        logic is_load_str;
        logic cnt_last;
        logic q_zero;
        logic addr_end;
        logic pend_valid;
        logic out_free;
    } tbm_stat_t;

endpackage

// ----- design/typed_byte_memory.sv -----
// typed_byte_memory: top level of the typed byte memory
// joins the sequencer tbm_ctrl and the datapath tbm_datapath; depends on tbm_pkg
//
// usage:
//   input channel (in_valid/in_stall) takes one command word: sized store or load,
//   one byte of a string store, or a string load. output channel (out_valid/out_stall)
//   gives result words: status, load_value, has_value, last.
//   cfg_write/cfg_data set the size limit while the block is idle.
// sequencing:
//   every command enters DISPATCH; a violation then goes to FINISH for its result
//   store: a STORE state per byte, FINISH; load: a LOAD state per byte, LWAIT, FINISH
//   string load: SREAD reads each byte walked and SCHK checks it
//   in_stall drops again the cycle after the final result is loaded, so an item
//   is taken while that result still waits in the output register
// reset: size goes to 64, per-byte valid flags clear so every byte reads zero at once
// output stall: the held result stays; a string load waits with its next character
module typed_byte_memory #(
    parameter int DEPTH = 64
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [tbm_pkg::SIZE_W-1:0]     cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [2:0]                     command,
    input  logic [15:0]                    position,
    input  logic signed [31:0]             store_value,
    input  logic [15:0]                    string_index,
    input  logic [15:0]                    string_length,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic                           status,
    output logic signed [31:0]             load_value,
    output logic                           has_value,
    output logic                           last
);

    tbm_pkg::tbm_ctrl_t ctrl;
    tbm_pkg::tbm_stat_t stat;

    tbm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .ctrl     (ctrl)
    );

    tbm_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_data      (cfg_data),
        .command       (command),
        .position      (position),
        .store_value   (store_value),
        .string_index  (string_index),
        .string_length (string_length),
        .out_stall     (out_stall),
        .ctrl          (ctrl),
        .stat          (stat),
        .out_valid     (out_valid),
        .status        (status),
        .load_value    (load_value),
        .has_value     (has_value),
        .last          (last)
    );

endmodule

// ----- design/tbm_datapath.sv -----
// tbm_datapath: byte memory, size register, access checks, accumulator and output register
// driven by tbm_ctrl through tbm_pkg::tbm_ctrl_t, reports through tbm_pkg::tbm_stat_t
// depends on tbm_pkg
module tbm_datapath #(
    parameter int DEPTH = 64
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [tbm_pkg::SIZE_W-1:0]       cfg_data,
    input  logic [2:0]                       command,
    input  logic [15:0]                      position,
    input  logic signed [31:0]               store_value,
    input  logic [15:0]                      string_index,
    input  logic [15:0]                      string_length,
    input  logic                             out_stall,
    input  tbm_pkg::tbm_ctrl_t               ctrl,
    output tbm_pkg::tbm_stat_t               stat,
    output logic                             out_valid,
    output logic                             status,
    output logic signed [31:0]               load_value,
    output logic                             has_value,
    output logic                             last
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SW = tbm_pkg::SIZE_W;

    logic [7:0]       mem [DEPTH];
    logic [DEPTH-1:0] vld_reg;

    logic [SW-1:0]    memory_size_reg;
    logic [SW-1:0]    size_act;

    tbm_pkg::cmd_t    cmd_reg;
    logic             viol_reg;
    logic [AW-1:0]    addr_reg;
    logic [1:0]       cnt_reg;
    logic [31:0]      sv_reg;
    logic [7:0]       rdata_reg;
    logic             rvld_reg;
    logic             rd_d_reg;
    logic [1:0]       idx_d_reg;
    logic [31:0]      acc_reg;
    logic [7:0]       char_reg;
    logic             pend_valid_reg;

    logic             out_valid_reg;
    logic             status_reg;
    logic [31:0]      load_value_reg;
    logic             has_value_reg;
    logic             last_reg;

    tbm_pkg::cmd_t    cmd_in;
    logic [2:0]       n_in;
    logic             viol_next;
    logic [AW-1:0]    addr_start;
    logic [7:0]       q;
    logic [1:0]       cnt_max;
    logic [31:0]      acc_ext;

    assign size_act = (memory_size_reg > SW'(DEPTH)) ? SW'(DEPTH) : memory_size_reg;
    assign cmd_in   = tbm_pkg::cmd_t'(command);

    always_comb
    begin
        case (command[1:0])
            2'd1:    n_in = 3'd2;
            2'd2:    n_in = 3'd4;
            default: n_in = 3'd1;
        endcase
    end

    // access checks are taken on the incoming word, before it is registered
    always_comb
    begin
        case (cmd_in)
            tbm_pkg::CMD_STORE_STR:
                viol_next = (({1'b0, position} + {1'b0, string_length}) > 17'(size_act))
                            || (string_index >= string_length);
            tbm_pkg::CMD_LOAD_STR:
                viol_next = position >= 16'(size_act);
            default:
                viol_next = ({1'b0, position} + 17'(n_in)) > 17'(size_act);
        endcase
    end

    assign addr_start = (cmd_in == tbm_pkg::CMD_STORE_STR)
                        ? (position[AW-1:0] + string_index[AW-1:0]) : position[AW-1:0];

    always_comb
    begin
        case (cmd_reg[1:0])
            2'd1:    cnt_max = 2'd1;
            2'd2:    cnt_max = 2'd3;
            default: cnt_max = 2'd0;
        endcase
    end

    // a byte never written reads as zero
    assign q = rvld_reg ? rdata_reg : 8'd0;

    assign acc_ext = (cmd_reg == tbm_pkg::CMD_LOAD_HALF)
                     ? {{16{acc_reg[15]}}, acc_reg[15:0]} : acc_reg;

    always_comb
    begin
        stat.viol          = viol_reg;
        stat.is_store      = (cmd_reg[2] == 1'b0);
        stat.is_load_fixed = cmd_reg[2] && (cmd_reg != tbm_pkg::CMD_LOAD_STR);
        stat.is_load_str   = (cmd_reg == tbm_pkg::CMD_LOAD_STR);
        stat.cnt_last      = (cnt_reg == cnt_max);
        stat.q_zero        = (q == 8'd0);
        stat.addr_end      = ((SW'(addr_reg) + SW'(1)) == size_act);
        stat.pend_valid    = pend_valid_reg;
        stat.out_free      = !out_valid_reg || !out_stall;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            memory_size_reg <= tbm_pkg::SIZE_RESET;
        end
        else if (cfg_write)
        begin
            memory_size_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.wr)
        begin
            mem[addr_reg] <= sv_reg[7:0];
        end
        if (ctrl.rd)
        begin
            rdata_reg <= mem[addr_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            rvld_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.wr)
            begin
                vld_reg[addr_reg] <= 1'b1;
            end
            if (ctrl.rd)
            begin
                rvld_reg <= vld_reg[addr_reg];
            end
        end
    end

    // word registers and address walker
    always_ff @(posedge clk)
    begin
        if (ctrl.accept)
        begin
            cmd_reg  <= cmd_in;
            viol_reg <= viol_next;
            addr_reg <= addr_start;
            cnt_reg  <= 2'd0;
            sv_reg   <= store_value;
        end
        else if (ctrl.step)
        begin
            addr_reg <= addr_reg + AW'(1);
            cnt_reg  <= cnt_reg + 2'd1;
            sv_reg   <= {8'd0, sv_reg[31:8]};
        end
        if (ctrl.rd)
        begin
            idx_d_reg <= cnt_reg;
        end
        if (ctrl.accept)
        begin
            acc_reg <= '0;
        end
        else if (rd_d_reg)
        begin
            acc_reg[8*idx_d_reg +: 8] <= q;
        end
        if (ctrl.pend_load)
        begin
            char_reg <= q;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_d_reg       <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            rd_d_reg <= ctrl.rd && stat.is_load_fixed;
            if (ctrl.accept)
            begin
                pend_valid_reg <= 1'b0;
            end
            else if (ctrl.pend_load)
            begin
                pend_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctrl.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.out_load)
        begin
            last_reg <= ctrl.out_last;
            case (ctrl.out_src)
                tbm_pkg::SRC_VIOL:
                begin
                    status_reg     <= 1'b1;
                    load_value_reg <= '0;
                    has_value_reg  <= 1'b0;
                end
                tbm_pkg::SRC_ACC:
                begin
                    status_reg     <= 1'b0;
                    load_value_reg <= acc_ext;
                    has_value_reg  <= 1'b1;
                end
                tbm_pkg::SRC_CHAR:
                begin
                    status_reg     <= 1'b0;
                    load_value_reg <= {24'd0, char_reg};
                    has_value_reg  <= 1'b1;
                end
                default:
                begin
                    status_reg     <= 1'b0;
                    load_value_reg <= '0;
                    has_value_reg  <= 1'b0;
                end
            endcase
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign load_value = load_value_reg;
    assign has_value  = has_value_reg;
    assign last       = last_reg;

endmodule

// ----- design/tbm_ctrl.sv -----
// tbm_ctrl: sequencer for the typed byte memory
// walks stores and fixed loads one byte a cycle and paces results to the output register
// depends on tbm_pkg
module tbm_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  tbm_pkg::tbm_stat_t  stat,
    output tbm_pkg::tbm_ctrl_t  ctrl
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_STORE,
        ST_LOAD,
        ST_LWAIT,
        ST_SREAD,
        ST_SCHK,
        ST_SLAST,
        ST_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        ctrl       = '0;
        ctrl.out_src = tbm_pkg::SRC_NOVAL;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    ctrl.accept = 1'b1;
                    state_next  = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                if (stat.viol)
                    state_next = ST_FINISH;
                else if (stat.is_store)
                    state_next = ST_STORE;
                else if (stat.is_load_fixed)
                    state_next = ST_LOAD;
                else if (stat.is_load_str)
                    state_next = ST_SREAD;
                else
                    state_next = ST_FINISH;
            end
            ST_STORE:
            begin
                ctrl.wr   = 1'b1;
                ctrl.step = 1'b1;
                if (stat.cnt_last)
                    state_next = ST_FINISH;
            end
            ST_LOAD:
            begin
                ctrl.rd   = 1'b1;
                ctrl.step = 1'b1;
                if (stat.cnt_last)
                    state_next = ST_LWAIT;
            end
            ST_LWAIT:
            begin
                state_next = ST_FINISH;
            end
            ST_SREAD:
            begin
                ctrl.rd    = 1'b1;
                state_next = ST_SCHK;
            end
            ST_SCHK:
            begin
                // the held character is sent once the next byte shows whether it is the last
                if (!stat.pend_valid)
                begin
                    if (stat.q_zero)
                    begin
                        if (stat.out_free)
                        begin
                            ctrl.out_load = 1'b1;
                            ctrl.out_src  = tbm_pkg::SRC_NOVAL;
                            ctrl.out_last = 1'b1;
                            state_next    = ST_IDLE;
                        end
                    end
                    else
                    begin
                        ctrl.pend_load = 1'b1;
                        ctrl.step      = 1'b1;
                        state_next     = stat.addr_end ? ST_SLAST : ST_SREAD;
                    end
                end
                else if (stat.out_free)
                begin
                    ctrl.out_load = 1'b1;
                    ctrl.out_src  = tbm_pkg::SRC_CHAR;
                    if (stat.q_zero)
                    begin
                        ctrl.out_last = 1'b1;
                        state_next    = ST_IDLE;
                    end
                    else
                    begin
                        ctrl.pend_load = 1'b1;
                        ctrl.step      = 1'b1;
                        state_next     = stat.addr_end ? ST_SLAST : ST_SREAD;
                    end
                end
            end
            ST_SLAST:
            begin
                if (stat.out_free)
                begin
                    ctrl.out_load = 1'b1;
                    ctrl.out_src  = tbm_pkg::SRC_CHAR;
                    ctrl.out_last = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_FINISH:
            begin
                if (stat.out_free)
                begin
                    ctrl.out_load = 1'b1;
                    ctrl.out_last = 1'b1;
                    if (stat.viol)
                        ctrl.out_src = tbm_pkg::SRC_VIOL;
                    else if (stat.is_load_fixed)
                        ctrl.out_src = tbm_pkg::SRC_ACC;
                    else
                        ctrl.out_src = tbm_pkg::SRC_NOVAL;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            in_stall  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            in_stall  <= (state_next != ST_IDLE);
        end
    end

endmodule
